// ===== sv/circle_rasterizer_macros.svh =====
// Assertion macros shared by the circle rasterizer RTL.
`ifndef CIRCLE_RASTERIZER_MACROS_SVH
`define CIRCLE_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS
// Immediate-implication or plain property, sampled on clk, off while in reset.
`define CRZ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("circle_rasterizer: assertion failed");
// Condition a must be followed by b in the next cycle.
`define CRZ_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("circle_rasterizer: assertion failed");
`else
`define CRZ_ASSERT(lbl, clk, rst_n, prop)
`define CRZ_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

// ===== sv/crz_pkg.sv =====
// Shared widths, request codes and the snapshot type of the circle rasterizer.
package crz_pkg;

  localparam int CoordW = 12;  // centre column / row
  localparam int RadW   = 11;  // radius
  localparam int PosW   = 13;  // running x / y
  localparam int DecW   = 16;  // decision variable
  localparam int PixW   = 14;  // emitted pixel coordinate

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // One point of the circle with everything needed to emit its eight mirrors.
  typedef struct packed {
    logic [CoordW-1:0]      cx;
    logic [CoordW-1:0]      cy;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic                   done;
  } crz_snap_t;

endpackage

// ===== sv/crz_req_if.sv =====
// Request channel: start or advance items with valid/ready handshake.
interface crz_req_if;
  import crz_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CoordW-1:0] center_x;
  logic [CoordW-1:0] center_y;
  logic [RadW-1:0]   radius;

  modport source (output valid, req_type, center_x, center_y, radius, input ready);
  modport sink   (input valid, req_type, center_x, center_y, radius, output ready);
endinterface

// ===== sv/crz_pix_if.sv =====
// Pixel channel: one mirrored pixel per transfer with valid/ready handshake.
interface crz_pix_if;
  import crz_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PixW-1:0] pixel_x;
  logic signed [PixW-1:0] pixel_y;
  logic                   last_of_step;
  logic                   circle_done;

  modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, circle_done, output ready);
endinterface

// ===== sv/crz_step.sv =====
// Midpoint circle state: start setup and one iteration per accepted advance until done.
`include "circle_rasterizer_macros.svh"

module crz_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic                       req_type_i,
  input  logic [crz_pkg::CoordW-1:0] center_x_i,
  input  logic [crz_pkg::CoordW-1:0] center_y_i,
  input  logic [crz_pkg::RadW-1:0]   radius_i,
  output logic                       push_o,
  output crz_pkg::crz_snap_t         snap_o
);
  import crz_pkg::*;

  logic signed [PosW-1:0] cur_x_q, cur_x_d;
  logic signed [PosW-1:0] cur_y_q, cur_y_d;
  logic signed [DecW-1:0] dec_q, dec_d;
  logic [CoordW-1:0]      ccol_q, ccol_d;
  logic [CoordW-1:0]      crow_q, crow_d;
  logic                   fin_q, fin_d;

  logic signed [PosW-1:0] x_inc, y_nxt;
  logic signed [DecW-1:0] diff16, dec_step;
  logic                   start_acc, adv_acc;

  assign start_acc = acc_i && (req_type_i == REQ_START);
  assign adv_acc   = acc_i && (req_type_i == REQ_STEP) && !fin_q;

  always_comb begin
    x_inc = cur_x_q + PosW'(1);
    if (dec_q > 0) begin
      y_nxt  = cur_y_q - PosW'(1);
      // 4*(x - y) + 10, taken modulo the decision width
      diff16 = DecW'(x_inc) - DecW'(y_nxt);
      diff16 = {diff16[DecW-3:0], 2'b00};
      dec_step = dec_q + diff16 + DecW'(10);
    end else begin
      y_nxt  = cur_y_q;
      diff16 = DecW'(x_inc);
      diff16 = {diff16[DecW-3:0], 2'b00};
      dec_step = dec_q + diff16 + DecW'(6);
    end
  end

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    dec_d   = dec_q;
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    fin_d   = fin_q;
    if (start_acc) begin
      cur_x_d = '0;
      cur_y_d = {{(PosW-RadW){1'b0}}, radius_i};
      dec_d   = DecW'(3) - {{(DecW-RadW-1){1'b0}}, radius_i, 1'b0};
      ccol_d  = center_x_i;
      crow_d  = center_y_i;
      fin_d   = 1'b0;  // y = r >= 0 = x
    end else if (adv_acc) begin
      cur_x_d = x_inc;
      cur_y_d = y_nxt;
      dec_d   = dec_step;
      fin_d   = (y_nxt < x_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      dec_q   <= '0;
      ccol_q  <= '0;
      crow_q  <= '0;
      fin_q   <= 1'b1;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      dec_q   <= dec_d;
      ccol_q  <= ccol_d;
      crow_q  <= crow_d;
      fin_q   <= fin_d;
    end
  end

  assign push_o      = start_acc || adv_acc;
  assign snap_o.cx   = ccol_d;
  assign snap_o.cy   = crow_d;
  assign snap_o.x    = cur_x_d;
  assign snap_o.y    = cur_y_d;
  assign snap_o.done = fin_d;

  `CRZ_ASSERT(fin_clears_only_on_start, clk_i, rst_ni, $fell(fin_q) |-> $past(start_acc))
  `CRZ_ASSERT(start_never_done, clk_i, rst_ni, start_acc |-> !snap_o.done)
endmodule

// ===== sv/crz_octant.sv =====
// Eight-way mirror emitter: pending slot, active point and output register.
`include "circle_rasterizer_macros.svh"

module crz_octant (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  crz_pkg::crz_snap_t snap_i,
  output logic               ready_o,
  crz_pix_if.source          pix_o
);
  import crz_pkg::*;

  logic      pend_v_q, pend_v_d;
  crz_snap_t pend_q;
  logic      act_v_q, act_v_d;
  crz_snap_t act_q;
  logic [2:0] idx_q, idx_d;

  logic                   out_v_q, out_v_d;
  logic signed [PixW-1:0] out_x_q, out_y_q;
  logic                   out_last_q, out_done_q;

  logic out_free, gen, last_gen, act_free, load;
  logic signed [PosW-1:0] off_c, off_r;
  logic [PixW-1:0]        add_c, add_r, px, py;

  assign out_free = !out_v_q || pix_o.ready;
  assign gen      = act_v_q && out_free;
  assign last_gen = gen && (idx_q == 3'd7);
  assign act_free = !act_v_q || last_gen;
  assign load     = act_free && pend_v_q;
  assign ready_o  = !pend_v_q || act_free;

  // idx[2] swaps x/y, idx[0] negates the column term, idx[1] the row term
  always_comb begin
    off_c = idx_q[2] ? act_q.y : act_q.x;
    off_r = idx_q[2] ? act_q.x : act_q.y;
    add_c = {off_c[PosW-1], off_c};
    add_r = {off_r[PosW-1], off_r};
    if (idx_q[0]) add_c = -add_c;
    if (idx_q[1]) add_r = -add_r;
    px = {{(PixW-CoordW){1'b0}}, act_q.cx} + add_c;
    py = {{(PixW-CoordW){1'b0}}, act_q.cy} + add_r;
  end

  always_comb begin
    pend_v_d = pend_v_q;
    if (push_i)    pend_v_d = 1'b1;
    else if (load) pend_v_d = 1'b0;

    act_v_d = act_v_q;
    idx_d   = idx_q;
    if (gen) idx_d = idx_q + 3'd1;
    if (load) begin
      act_v_d = 1'b1;
      idx_d   = '0;
    end else if (last_gen) begin
      act_v_d = 1'b0;
    end

    out_v_d = out_v_q;
    if (gen)              out_v_d = 1'b1;
    else if (pix_o.ready) out_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      act_v_q  <= 1'b0;
      idx_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      act_v_q  <= act_v_d;
      idx_q    <= idx_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) pend_q <= snap_i;
    if (load)   act_q  <= pend_q;
    if (gen) begin
      out_x_q    <= px;
      out_y_q    <= py;
      out_last_q <= (idx_q == 3'd7);
      out_done_q <= (idx_q == 3'd7) && act_q.done;
    end
  end

  assign pix_o.valid        = out_v_q;
  assign pix_o.pixel_x      = out_x_q;
  assign pix_o.pixel_y      = out_y_q;
  assign pix_o.last_of_step = out_last_q;
  assign pix_o.circle_done  = out_done_q;

  `CRZ_ASSERT(done_only_on_last, clk_i, rst_ni, (out_v_q && out_done_q) |-> out_last_q)
  `CRZ_ASSERT_NEXT(pend_moves_to_idle_active, clk_i, rst_ni, pend_v_q && !act_v_q, act_v_q)
  `CRZ_ASSERT(active_starts_at_first, clk_i, rst_ni, $rose(act_v_q) |-> (idx_q == 3'd0))
endmodule

// ===== sv/circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer.
// A start request (req_type 0) latches centre and radius and produces the eight mirrored
// pixels of (0, r); each advance request (req_type 1) runs one midpoint iteration and
// produces eight more, the last of the final octant step flagged circle_done. Advances
// after the circle is complete are taken and produce nothing. The iteration itself is
// done in the cycle a request is accepted, so the state is ready for the next request at
// once; the pixel port then delivers one pixel per cycle while it is ready, so a stream of
// steps runs at one request per eight pixels, set by the single output channel. A request
// is held in a one-deep pending slot while the previous point is still being emitted, and
// the output is registered, so a stalled pixel port does not block the request side until
// that slot fills. Pixels come via the pending slot, active point and output register.
module circle_rasterizer (
  input  logic     clk_i,
  input  logic     rst_ni,
  crz_req_if.sink  req_i,
  crz_pix_if.source pix_o
);
  import crz_pkg::*;

  logic      acc;
  logic      push;
  logic      slot_ready;
  crz_snap_t snap;

  assign req_i.ready = slot_ready;
  assign acc         = req_i.valid && slot_ready;

  crz_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .req_type_i (req_i.req_type),
    .center_x_i (req_i.center_x),
    .center_y_i (req_i.center_y),
    .radius_i   (req_i.radius),
    .push_o     (push),
    .snap_o     (snap)
  );

  crz_octant u_octant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .snap_i  (snap),
    .ready_o (slot_ready),
    .pix_o   (pix_o)
  );
endmodule
